[rtl/machine_csr_file_defines.svh]
// Assertion macros shared by the machine CSR file RTL.
// Included by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef MACHINE_CSR_FILE_DEFINES_SVH
`define MACHINE_CSR_FILE_DEFINES_SVH
`ifndef SYNTH
// Check sampled on the rising clock edge, switched off while reset is asserted.
`define MCSR_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check sampled on the rising clock edge that also holds during reset.
`define MCSR_ASSERT_ALWAYS(lbl, prop, msg) \
lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MCSR_ASSERT(lbl, prop, msg)
`define MCSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/mcsr_pkg.sv]
// Package for the machine CSR file: select and register index codes, masks,
// reset values and the write-merge helpers. No dependencies.
`default_nettype none

package mcsr_pkg;

	// Dense CSR select encoding carried on the request.
	typedef enum logic [3:0] {
		CSR_MISA       = 4'd0,
		CSR_MVENDORID  = 4'd1,
		CSR_MARCHID    = 4'd2,
		CSR_MIMPID     = 4'd3,
		CSR_MHARTID    = 4'd4,
		CSR_MSTATUS    = 4'd5,
		CSR_MSTATUSH   = 4'd6,
		CSR_MCONFIGPTR = 4'd7,
		CSR_MTVEC      = 4'd8,
		CSR_MIP        = 4'd9,
		CSR_MIE        = 4'd10,
		CSR_MSCRATCH   = 4'd11,
		CSR_MEPC       = 4'd12,
		CSR_MCAUSE     = 4'd13,
		CSR_MTVAL      = 4'd14,
		CSR_RESERVED   = 4'd15
	} csr_sel_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_ISA_WORD       = 3'd0,
		CFG_VENDOR_ID      = 3'd1,
		CFG_ARCH_ID        = 3'd2,
		CFG_IMPL_ID        = 3'd3,
		CFG_HART_NUMBER    = 3'd4,
		CFG_CONFIG_POINTER = 3'd5,
		CFG_STATUS_HIGH    = 3'd6
	} cfg_idx_t;

	localparam int unsigned XLEN       = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned STATUS_W   = 13;
	localparam int unsigned IE_W       = 12;

	localparam logic [XLEN-1:0] MSTATUS_KEEP = 32'h0000_1888;
	localparam logic [XLEN-1:0] MSTATUS_MPP  = 32'h0000_1800;
	localparam logic [XLEN-1:0] MIE_KEEP     = 32'h0000_0888;
	localparam logic [XLEN-1:0] MTVEC_CLEAR  = 32'h0000_0002;
	localparam logic [XLEN-1:0] MEPC_CLEAR   = 32'h0000_0003;

	localparam logic [XLEN-1:0] ISA_WORD_RST = 32'h4000_0000;

	// Identity and fixed-value registers as seen by the datapath.
	typedef struct packed {
		logic [XLEN-1:0] isa_word;
		logic [XLEN-1:0] vendor_id;
		logic [XLEN-1:0] arch_id;
		logic [XLEN-1:0] impl_id;
		logic [XLEN-1:0] hart_number;
		logic [XLEN-1:0] config_pointer;
		logic [XLEN-1:0] status_high;
	} cfg_regs_t;

	// Replace the bits of old_val selected by wmask with those of wdata.
	function automatic logic [XLEN-1:0] merge(
		input logic [XLEN-1:0] old_val,
		input logic [XLEN-1:0] wmask,
		input logic [XLEN-1:0] wdata
	);
		return (old_val & ~wmask) | (wdata & wmask);
	endfunction

	// mstatus keeps MPP, MPIE and MIE; a nonzero MPP is forced to machine mode.
	function automatic logic [XLEN-1:0] status_rule(input logic [XLEN-1:0] val);
		logic [XLEN-1:0] kept;
		kept = val & MSTATUS_KEEP;
		if ((kept & MSTATUS_MPP) != '0) begin
			kept = kept | MSTATUS_MPP;
		end
		return kept;
	endfunction

endpackage

`default_nettype wire

[rtl/mcsr_cfg_bank.sv]
// Configuration register bank of the machine CSR file: identity values and mstatush.
// Depends on mcsr_pkg.
`default_nettype none

module mcsr_cfg_bank (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [mcsr_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [mcsr_pkg::XLEN-1:0]            wr_data,
	output mcsr_pkg::cfg_regs_t                       regs
);

	mcsr_pkg::cfg_regs_t regs_q;

	// Indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.isa_word       <= mcsr_pkg::ISA_WORD_RST;
			regs_q.vendor_id      <= '0;
			regs_q.arch_id        <= '0;
			regs_q.impl_id        <= '0;
			regs_q.hart_number    <= '0;
			regs_q.config_pointer <= '0;
			regs_q.status_high    <= '0;
		end else if (wr_en) begin
			unique case (mcsr_pkg::cfg_idx_t'(wr_index))
				mcsr_pkg::CFG_ISA_WORD:       regs_q.isa_word       <= wr_data;
				mcsr_pkg::CFG_VENDOR_ID:      regs_q.vendor_id      <= wr_data;
				mcsr_pkg::CFG_ARCH_ID:        regs_q.arch_id        <= wr_data;
				mcsr_pkg::CFG_IMPL_ID:        regs_q.impl_id        <= wr_data;
				mcsr_pkg::CFG_HART_NUMBER:    regs_q.hart_number    <= wr_data;
				mcsr_pkg::CFG_CONFIG_POINTER: regs_q.config_pointer <= wr_data;
				mcsr_pkg::CFG_STATUS_HIGH:    regs_q.status_high    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

[rtl/machine_csr_file.sv]
// Top level of the RV32 machine-mode CSR file: request pipeline, CSR state and write rules.
// Depends on mcsr_pkg, mcsr_cfg_bank and machine_csr_file_defines.svh.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   csr_select, csr_rmask, csr_wmask,
//                                              csr_wdata, pending_interrupts
//   out       source     out_valid / out_stall read_value, illegal_access
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low. A request passes through the input
// register and then the result register, from which its result is offered on the result port.
// The CSR state is read and updated in the cycle the request leaves the input register, so
// back-to-back requests see each other's writes in order.
// A stall on the result side holds the result register and then the input register; in_stall
// rises only when both are full and the result is stalled. Reset clears the valid flags and
// all CSR state except misa, which resets to ISA_WORD_RST; no clearing pass is needed.
// Configuration writes are always taken (cfg_ready stays high).
`default_nettype none
`include "machine_csr_file_defines.svh"

module machine_csr_file (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// request channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [3:0]                           csr_select,
	input  wire logic [mcsr_pkg::XLEN-1:0]            csr_rmask,
	input  wire logic [mcsr_pkg::XLEN-1:0]            csr_wmask,
	input  wire logic [mcsr_pkg::XLEN-1:0]            csr_wdata,
	input  wire logic [mcsr_pkg::XLEN-1:0]            pending_interrupts,
	// result channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [mcsr_pkg::XLEN-1:0]                 read_value,
	output logic                                      illegal_access,
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mcsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mcsr_pkg::XLEN-1:0]            cfg_data
);

	// Configuration bank. Writes must arrive only while the block is idle; the block itself
	// does not enforce this. The datapath reads these values directly without ordering logic.
	mcsr_pkg::cfg_regs_t cfg;

	assign cfg_ready = 1'b1;

	mcsr_cfg_bank u_cfg_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	// Input register. The whole request is captured on acceptance so that the
	// CSR lookup and merge see stable operands.
	logic                          s1_valid_q;
	mcsr_pkg::csr_sel_t            sel_s1;
	logic [mcsr_pkg::XLEN-1:0]     rmask_s1;
	logic [mcsr_pkg::XLEN-1:0]     wmask_s1;
	logic [mcsr_pkg::XLEN-1:0]     wdata_s1;
	logic [mcsr_pkg::XLEN-1:0]     pend_s1;

	// Result register.
	logic                          out_valid_q;
	logic [mcsr_pkg::XLEN-1:0]     read_value_q;
	logic                          illegal_q;

	// The result register can take a new entry when it is empty or being drained.
	logic out_free;
	logic s1_fire;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_fire  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sel_s1   <= mcsr_pkg::csr_sel_t'(csr_select);
			rmask_s1 <= csr_rmask;
			wmask_s1 <= csr_wmask;
			wdata_s1 <= csr_wdata;
			pend_s1  <= pending_interrupts;
		end
	end

	// Writable machine state; mstatus and mie are stored only as wide as their legal bits.
	logic [mcsr_pkg::STATUS_W-1:0] status_q;
	logic [mcsr_pkg::XLEN-1:0]     tvec_q;
	logic [mcsr_pkg::IE_W-1:0]     ie_q;
	logic [mcsr_pkg::XLEN-1:0]     scratch_q;
	logic [mcsr_pkg::XLEN-1:0]     epc_q;
	logic [mcsr_pkg::XLEN-1:0]     cause_q;
	logic [mcsr_pkg::XLEN-1:0]     tval_q;

	// Old value of the selected CSR and the illegal flag. Identity registers
	// reject any write; mip and mstatush accept and discard one.
	logic [mcsr_pkg::XLEN-1:0] old_val;
	logic                      bad;
	logic                      wr_any;

	assign wr_any = (wmask_s1 != '0);

	always_comb begin
		old_val = '0;
		bad     = 1'b0;
		unique case (sel_s1)
			mcsr_pkg::CSR_MISA: begin
				old_val = cfg.isa_word;
				bad     = wr_any;
			end
			mcsr_pkg::CSR_MVENDORID: begin
				old_val = cfg.vendor_id;
				bad     = wr_any;
			end
			mcsr_pkg::CSR_MARCHID: begin
				old_val = cfg.arch_id;
				bad     = wr_any;
			end
			mcsr_pkg::CSR_MIMPID: begin
				old_val = cfg.impl_id;
				bad     = wr_any;
			end
			mcsr_pkg::CSR_MHARTID: begin
				old_val = cfg.hart_number;
				bad     = wr_any;
			end
			mcsr_pkg::CSR_MCONFIGPTR: begin
				old_val = cfg.config_pointer;
				bad     = wr_any;
			end
			mcsr_pkg::CSR_MSTATUS:  old_val = {{(mcsr_pkg::XLEN-mcsr_pkg::STATUS_W){1'b0}},
				status_q};
			mcsr_pkg::CSR_MSTATUSH: old_val = cfg.status_high;
			mcsr_pkg::CSR_MTVEC:    old_val = tvec_q;
			mcsr_pkg::CSR_MIP:      old_val = pend_s1;
			mcsr_pkg::CSR_MIE:      old_val = {{(mcsr_pkg::XLEN-mcsr_pkg::IE_W){1'b0}}, ie_q};
			mcsr_pkg::CSR_MSCRATCH: old_val = scratch_q;
			mcsr_pkg::CSR_MEPC:     old_val = epc_q;
			mcsr_pkg::CSR_MCAUSE:   old_val = cause_q;
			mcsr_pkg::CSR_MTVAL:    old_val = tval_q;
			mcsr_pkg::CSR_RESERVED: bad     = 1'b1;
			default:                bad     = 1'b1;
		endcase
	end

	// Merged value before the per-CSR write rule is applied.
	logic [mcsr_pkg::XLEN-1:0] merged;
	logic [mcsr_pkg::XLEN-1:0] status_next;

	assign merged      = mcsr_pkg::merge(old_val, wmask_s1, wdata_s1);
	assign status_next = mcsr_pkg::status_rule(merged);

	// State update. A request with an empty write mask rewrites the same value,
	// which every write rule leaves unchanged, so no separate write-enable is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			tvec_q    <= '0;
			ie_q      <= '0;
			scratch_q <= '0;
			epc_q     <= '0;
			cause_q   <= '0;
			tval_q    <= '0;
		end else if (s1_fire) begin
			unique case (sel_s1)
				mcsr_pkg::CSR_MSTATUS:  status_q  <= status_next[mcsr_pkg::STATUS_W-1:0];
				mcsr_pkg::CSR_MTVEC:    tvec_q    <= merged & ~mcsr_pkg::MTVEC_CLEAR;
				mcsr_pkg::CSR_MIE: begin
					ie_q <= merged[mcsr_pkg::IE_W-1:0] & mcsr_pkg::MIE_KEEP[mcsr_pkg::IE_W-1:0];
				end
				mcsr_pkg::CSR_MSCRATCH: scratch_q <= merged;
				mcsr_pkg::CSR_MEPC:     epc_q     <= merged & ~mcsr_pkg::MEPC_CLEAR;
				mcsr_pkg::CSR_MCAUSE:   cause_q   <= merged;
				mcsr_pkg::CSR_MTVAL:    tval_q    <= merged;
				default: begin
				end
			endcase
		end
	end

	// Result register: loaded when the input register hands over, cleared
	// once the consumer takes the result without a new one arriving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			read_value_q <= bad ? '0 : (old_val & rmask_s1);
			illegal_q    <= bad;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign illegal_access = illegal_q;

	// The configuration port never refuses a write.
	`MCSR_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port refused a write")
	// MPP only ever holds user or machine mode.
	`MCSR_ASSERT(a_mpp_legal, (status_q[12:11] == 2'b00) || (status_q[12:11] == 2'b11),
		"mstatus MPP holds a mode other than user or machine")
	// Alignment bits of mepc and the reserved mtvec bit stay clear.
	`MCSR_ASSERT(a_align_bits, (epc_q[1:0] == 2'b00) && (tvec_q[1] == 1'b0),
		"mepc or mtvec holds a bit that its write rule clears")
	// An illegal access never returns data.
	`MCSR_ASSERT(a_illegal_zero, (out_valid_q && illegal_q) |-> (read_value_q == '0),
		"illegal access returned nonzero read data")
	// With both registers full and the result stalled, no request may enter.
	`MCSR_ASSERT(a_full_stall, (s1_valid_q && out_valid_q && out_stall) |-> in_stall,
		"request accepted while the pipeline is full and stalled")
	// A handed-over request always lands in the result register.
	`MCSR_ASSERT(a_handover, s1_fire |=> out_valid_q,
		"result register empty after a request left the input register")

endmodule

`default_nettype wire
